// ===== sv/kda_pkg.sv =====
package kda_pkg;

	localparam int MASK_W      = 4;
	localparam int KEY_W       = 2;
	localparam int CNT_W       = 8;
	localparam int CFG_ADDR_W  = 3;
	localparam int MAX_EVENTS  = 4;
	localparam int SLOT_W      = $clog2(MAX_EVENTS);
	localparam int EVC_W       = $clog2(MAX_EVENTS + 1);
	localparam int NUM_KEYS_DEF = 4;

	localparam logic [CNT_W-1:0] SCAN_PERIOD_RST    = 8'd10;
	localparam logic [CNT_W-1:0] DEBOUNCE_LIMIT_RST = 8'd3;
	localparam logic [CNT_W-1:0] REPEAT_DELAY_RST   = 8'd70;
	localparam logic [CNT_W-1:0] REPEAT_RELOAD_RST  = 8'd60;
	localparam logic [CNT_W-1:0] FAST_AFTER_RST     = 8'd10;

	typedef enum logic [1:0] {
		KIND_PRESS   = 2'd0,
		KIND_REPEAT  = 2'd1,
		KIND_FAST    = 2'd2,
		KIND_RELEASE = 2'd3
	} kind_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_SCAN_PERIOD    = 3'd0,
		REG_DEBOUNCE_LIMIT = 3'd1,
		REG_REPEAT_DELAY   = 3'd2,
		REG_REPEAT_RELOAD  = 3'd3,
		REG_FAST_AFTER     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_index;
		kind_t            event_kind;
	} event_t;

	typedef struct packed {
		logic                        en;
		logic [EVC_W-1:0]            cnt;
		event_t [MAX_EVENTS-1:0]     slots;
	} evload_t;

endpackage

// ===== sv/kda_tick_if.sv =====
interface kda_tick_if import kda_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] pressed_mask;

	modport source (output valid, output pressed_mask, input ready);
	modport sink (input valid, input pressed_mask, output ready);
endinterface

// ===== sv/kda_event_if.sv =====
interface kda_event_if import kda_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key_index;
	kind_t            event_kind;
	logic             last;

	modport source (output valid, output key_index, output event_kind, output last,
		input ready);
	modport sink (input valid, input key_index, input event_kind, input last,
		output ready);
endinterface

// ===== sv/kda_cfg_if.sv =====
interface kda_cfg_if import kda_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CNT_W-1:0]      data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== sv/key_debounce_autorepeat.sv =====
// Debounced scanner for NUM_KEYS keys with two-stage autorepeat. Each tick word carries the
// pressed mask (1 = pressed, bit 0 = key 0); every scan_period-th tick runs a scan that may
// raise press, repeat, fast repeat and release events, at most four per tick, in key order,
// with last set on the final one. A tick word is taken every cycle while the input register
// is empty or advancing; it is held in the input register, and a tick that raises events
// then moves into the four-word event buffer, which delivers one event word per cycle while
// evt.ready is high; a following tick with events waits in the input register until the
// buffer drains. Ticks without events never wait. Configuration writes are taken at any time.
module key_debounce_autorepeat import kda_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	kda_cfg_if.sink     cfg,
	kda_tick_if.sink    tick,
	kda_event_if.source evt
);

	logic [CNT_W-1:0] scan_period_q;
	logic [CNT_W-1:0] debounce_limit_q;
	logic [CNT_W-1:0] repeat_delay_q;
	logic [CNT_W-1:0] repeat_reload_q;
	logic [CNT_W-1:0] fast_after_q;

	logic              valid_s1;
	logic [MASK_W-1:0] mask_s1;

	logic [CNT_W-1:0] countdown_q;
	logic [CNT_W-1:0] countdown_dec;
	logic             scan;

	logic             down_q     [NUM_KEYS];
	logic [CNT_W-1:0] debounce_q [NUM_KEYS];
	logic [CNT_W-1:0] repeat_q   [NUM_KEYS];
	logic [CNT_W-1:0] plain_q    [NUM_KEYS];

	logic             down_d     [NUM_KEYS];
	logic [CNT_W-1:0] debounce_d [NUM_KEYS];
	logic [CNT_W-1:0] repeat_d   [NUM_KEYS];
	logic [CNT_W-1:0] plain_d    [NUM_KEYS];
	logic             ev_v       [NUM_KEYS];
	kind_t            ev_kind    [NUM_KEYS];

	logic [NUM_KEYS+MASK_W-1:0] mask_ext;
	evload_t                    ld;
	logic                       can_load;
	logic                       adv;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q    <= SCAN_PERIOD_RST;
			debounce_limit_q <= DEBOUNCE_LIMIT_RST;
			repeat_delay_q   <= REPEAT_DELAY_RST;
			repeat_reload_q  <= REPEAT_RELOAD_RST;
			fast_after_q     <= FAST_AFTER_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.addr))
				REG_SCAN_PERIOD:    scan_period_q    <= cfg.data;
				REG_DEBOUNCE_LIMIT: debounce_limit_q <= cfg.data;
				REG_REPEAT_DELAY:   repeat_delay_q   <= cfg.data;
				REG_REPEAT_RELOAD:  repeat_reload_q  <= cfg.data;
				REG_FAST_AFTER:     fast_after_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	assign adv        = valid_s1 && ((ld.cnt == '0) || can_load);
	assign tick.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			mask_s1 <= tick.pressed_mask;
		end
	end

	assign countdown_dec = countdown_q - CNT_W'(1);
	assign scan          = (countdown_dec == '0);
	assign mask_ext      = (NUM_KEYS + MASK_W)'(mask_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= SCAN_PERIOD_RST;
		end else if (adv) begin
			countdown_q <= scan ? scan_period_q : countdown_dec;
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			down_d[k]     = down_q[k];
			debounce_d[k] = debounce_q[k];
			repeat_d[k]   = repeat_q[k];
			plain_d[k]    = plain_q[k];
			ev_v[k]       = 1'b0;
			ev_kind[k]    = KIND_PRESS;
			if (!down_q[k]) begin
				if (!mask_ext[k]) begin
					debounce_d[k] = '0;
				end else if ((debounce_q[k] + CNT_W'(1)) > debounce_limit_q) begin
					down_d[k]     = 1'b1;
					debounce_d[k] = '0;
					repeat_d[k]   = '0;
					ev_v[k]       = 1'b1;
					ev_kind[k]    = KIND_PRESS;
				end else begin
					debounce_d[k] = debounce_q[k] + CNT_W'(1);
				end
			end else if (mask_ext[k]) begin
				debounce_d[k] = '0;
				if ((repeat_q[k] + CNT_W'(1)) > repeat_delay_q) begin
					ev_v[k]     = 1'b1;
					repeat_d[k] = repeat_reload_q;
					if (plain_q[k] > fast_after_q) begin
						ev_kind[k] = KIND_FAST;
					end else begin
						ev_kind[k] = KIND_REPEAT;
						plain_d[k] = plain_q[k] + CNT_W'(1);
					end
				end else begin
					repeat_d[k] = repeat_q[k] + CNT_W'(1);
				end
			end else if ((debounce_q[k] + CNT_W'(1)) > debounce_limit_q) begin
				down_d[k]     = 1'b0;
				debounce_d[k] = '0;
				repeat_d[k]   = '0;
				plain_d[k]    = '0;
				ev_v[k]       = 1'b1;
				ev_kind[k]    = KIND_RELEASE;
			end else begin
				debounce_d[k] = debounce_q[k] + CNT_W'(1);
			end
		end
	end

	// pack events in key order, drop those past the buffer depth
	always_comb begin
		ld.cnt   = '0;
		ld.slots = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (scan && ev_v[k] && (ld.cnt < EVC_W'(MAX_EVENTS))) begin
				ld.slots[ld.cnt[SLOT_W-1:0]].key_index  = KEY_W'(k);
				ld.slots[ld.cnt[SLOT_W-1:0]].event_kind = ev_kind[k];
				ld.cnt = ld.cnt + EVC_W'(1);
			end
		end
		ld.en = adv && (ld.cnt != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				down_q[k]     <= 1'b0;
				debounce_q[k] <= '0;
				repeat_q[k]   <= '0;
				plain_q[k]    <= '0;
			end
		end else if (adv && scan) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				down_q[k]     <= down_d[k];
				debounce_q[k] <= debounce_d[k];
				repeat_q[k]   <= repeat_d[k];
				plain_q[k]    <= plain_d[k];
			end
		end
	end

	kda_event_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld),
		.can_load (can_load),
		.evt      (evt)
	);

endmodule

// ===== sv/kda_event_queue.sv =====
module kda_event_queue import kda_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  evload_t     ld,
	output logic        can_load,
	kda_event_if.source evt
);

	event_t [MAX_EVENTS-1:0] slot_q;
	logic [EVC_W-1:0]        cnt_q;
	logic                    pop;

	assign pop      = evt.valid && evt.ready;
	assign can_load = (cnt_q == '0) || ((cnt_q == EVC_W'(1)) && pop);

	assign evt.valid      = (cnt_q != '0);
	assign evt.key_index  = slot_q[0].key_index;
	assign evt.event_kind = slot_q[0].event_kind;
	assign evt.last       = (cnt_q == EVC_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ld.en) begin
			cnt_q <= ld.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - EVC_W'(1);
		end
	end

	// load the buffer from a scan, else advance the queue head on each taken word
	always_ff @(posedge clk) begin
		if (ld.en) begin
			slot_q <= ld.slots;
		end else if (pop) begin
			for (int j = 0; j < MAX_EVENTS - 1; j++) begin
				slot_q[j] <= slot_q[j+1];
			end
		end
	end

endmodule
